// ----- rtl/cpa_pkg.sv -----
// Shared types and constants for the contiguous page allocator.
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

  localparam int PageBits    = 12;
  localparam int TotalPages  = 16384;
  localparam int LowestPage  = 16;
  localparam int PageW       = $clog2(TotalPages);
  localparam int LenW        = 15;
  localparam int UsableW     = 15;
  localparam int UsableReset = 16384;
  localparam int AddrPgW     = 32 - PageBits;
  localparam int NumW        = AddrPgW + 1;

  // register index, taken from paddr[2]
  localparam logic REG_USABLE_PAGES = 1'b0;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RESERVE = 2'd1,
    KIND_FREE    = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_BAD_ALIGN = 3'd2,
    ST_NO_FIT    = 3'd3,
    ST_TAKEN     = 3'd4,
    ST_NO_BLOCK  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_CLAIM,
    S_LEN,
    S_FREE,
    S_REPLY
  } state_e;

  typedef struct packed {
    logic             bm_we;
    logic [PageW-1:0] bm_waddr;
    logic             bm_wdata;
    logic [PageW-1:0] bm_raddr;
    logic             len_we;
    logic [PageW-1:0] len_waddr;
    logic [LenW-1:0]  len_wdata;
    logic [PageW-1:0] len_raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/cpa_if.sv -----
// Request and response channel interfaces of the page allocator.
`timescale 1ns / 1ps
`default_nettype none

interface cpa_req_if;
  logic           valid;
  logic           ready;
  cpa_pkg::kind_e kind;
  logic [31:0]    size_bytes;
  logic [31:0]    min_address;
  logic [31:0]    max_address;
  logic [31:0]    align_bytes;
  logic [31:0]    base_address;

  modport source (output valid, kind, size_bytes, min_address, max_address, align_bytes,
                  base_address, input ready);
  modport sink (input valid, kind, size_bytes, min_address, max_address, align_bytes,
                base_address, output ready);
endinterface

interface cpa_rsp_if;
  logic             valid;
  logic             ready;
  cpa_pkg::status_e status;
  logic [31:0]      block_address;
  logic [31:0]      block_bytes;

  modport source (output valid, status, block_address, block_bytes, input ready);
  modport sink (input valid, status, block_address, block_bytes, output ready);
endinterface

`default_nettype wire

// ----- rtl/contiguous_page_allocator_unit.sv -----
// Top level of the contiguous page allocator.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Moves
// req_i     sink    one request transaction: kind, size, window, alignment, base
// rsp_o     source  one response transaction per request: status, address, bytes
// APB       slave   usable_pages register at byte address 0
//
// Order: allocate and reserve decode the request, then walk the bitmap scan (one page
//   per cycle, from the top candidate run end down to the low bound or the first fit),
//   then claim the pages found. Free reads the block length, then clears its pages;
//   query replies after the length read, early rejects after decode. The single bitmap port sets the pace.
// Reset: after rst_ni rises, a clearing pass zeroes both memories;
//   requests are held off meanwhile, APB writes are taken.
// Stalls: a finished response waits in the output register while the next
//   request is accepted; a result only waits in S_REPLY if that register is full.

module contiguous_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpa_req_if.sink     req_i,
  cpa_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cpa_pkg::*;

  state_e state_q, state_d;

  logic [UsableW-1:0] usable_q, usable_d;
  logic [PageW-1:0]   clr_q, clr_d;

  // latched request
  kind_e       kind_q;
  logic [31:0] size_q, min_q, max_q, align_q, base_q;

  // scan control
  logic [NumW-1:0]  n_q, n_d;
  logic [PageW-1:0] mask_q, mask_d;
  logic [PageW-1:0] lo_q, lo_d;
  logic [PageW-1:0] hic_q, hic_d;
  logic [PageW-1:0] ra_q, ra_d;
  logic             iss_q, iss_d;
  logic [PageW-1:0] pi_q, pi_d;
  logic             pv_q, pv_d;
  logic [LenW-1:0]  run_q, run_d;
  status_e          fail_q, fail_d;

  // claim / free walk
  logic [PageW-1:0] ptr_q, ptr_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [PageW-1:0] bp_q, bp_d;

  // pending result
  status_e     st_q, st_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] bytes_q, bytes_d;

  // output register
  logic        rsp_valid_q, rsp_valid_d;
  status_e     rsp_st_q, rsp_st_d;
  logic [31:0] rsp_addr_q, rsp_addr_d;
  logic [31:0] rsp_bytes_q, rsp_bytes_d;

  mem_req_t        mem_req;
  logic            bm_rd;
  logic [LenW-1:0] len_rd;

  cpa_mem u_mem (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .bm_rdata_o (bm_rd),
    .len_rdata_o(len_rd)
  );

  // ---------------- request decode (S_PREP) ----------------
  logic [32:0]        sz_sum, bs_sum;
  logic [NumW-1:0]    n_w, bp_w;
  logic [AddrPgW-1:0] lo_raw, hi_raw, lo_c, hi_c, lo_f, align_hi;
  logic [PageW-1:0]   hic_w, mask_w, start_w;
  logic [NumW-1:0]    st_sum;
  logic [NumW:0]      rs_end, rs_last;
  logic               bad_align;
  status_e            prep_st;
  logic               prep_scan, prep_len;
  logic [PageW-1:0]   prep_ra, prep_lo, prep_hic, prep_mask;

  always_comb begin
    sz_sum    = {1'b0, size_q} + 33'((1 << PageBits) - 1);
    bs_sum    = {1'b0, base_q} + 33'((1 << PageBits) - 1);
    n_w       = sz_sum[32:PageBits];
    bp_w      = bs_sum[32:PageBits];
    lo_raw    = min_q[31:PageBits];
    hi_raw    = max_q[31:PageBits];
    lo_c      = (lo_raw < AddrPgW'(LowestPage)) ? AddrPgW'(LowestPage) : lo_raw;
    hi_c      = (hi_raw > AddrPgW'(usable_q)) ? AddrPgW'(usable_q) : hi_raw;
    lo_f      = (lo_c > hi_c) ? hi_c : lo_c;
    hic_w     = (hi_c > AddrPgW'(TotalPages - 1)) ? PageW'(TotalPages - 1)
                                                  : hi_c[PageW-1:0];
    align_hi  = align_q[31:PageBits];
    mask_w    = (align_hi == '0) ? '0 : PageW'(align_hi - AddrPgW'(1));
    bad_align = (align_q & (align_q - 32'd1)) != '0;
    st_sum    = NumW'(hic_w) + n_w - NumW'(1);
    start_w   = (st_sum > NumW'(TotalPages - 1)) ? PageW'(TotalPages - 1)
                                                 : st_sum[PageW-1:0];
    rs_end    = {1'b0, bp_w} + {1'b0, n_w};
    rs_last   = rs_end - (NumW + 1)'(1);

    prep_st   = ST_OK;
    prep_scan = 1'b0;
    prep_len  = 1'b0;
    prep_ra   = start_w;
    prep_lo   = lo_f[PageW-1:0];
    prep_hic  = hic_w;
    prep_mask = mask_w;

    unique case (kind_q)
      KIND_ALLOC: begin
        if (size_q == '0) begin
          prep_st = ST_ZERO_SIZE;
        end else if (bad_align) begin
          prep_st = ST_BAD_ALIGN;
        end else if (lo_f > AddrPgW'(TotalPages - 1)) begin
          // every candidate base lies past memory
          prep_st = ST_NO_FIT;
        end else begin
          prep_scan = 1'b1;
        end
      end
      KIND_RESERVE: begin
        prep_ra   = rs_last[PageW-1:0];
        prep_lo   = bp_w[PageW-1:0];
        prep_hic  = bp_w[PageW-1:0];
        prep_mask = '0;
        if (size_q == '0) begin
          prep_st = ST_ZERO_SIZE;
        end else if (rs_end > (NumW + 1)'(TotalPages)) begin
          prep_st = ST_TAKEN;
        end else begin
          prep_scan = 1'b1;
        end
      end
      KIND_FREE, KIND_QUERY: begin
        if (bp_w > NumW'(TotalPages - 1)) begin
          prep_st = ST_NO_BLOCK;
        end else begin
          prep_len = 1'b1;
        end
      end
      default: prep_st = ST_NO_BLOCK;
    endcase
  end

  // ---------------- scan evaluation ----------------
  // run_q counts free pages contiguous upward from the page last examined
  logic [LenW-1:0] run_n;
  logic            cand_w, hit_w, last_w, reply_go;

  always_comb begin
    run_n    = bm_rd ? '0 : run_q + LenW'(1);
    cand_w   = pv_q && ((pi_q & mask_q) == '0) && (pi_q >= lo_q) && (pi_q <= hic_q);
    hit_w    = cand_w && (NumW'(run_n) >= n_q);
    last_w   = pv_q && (pi_q == lo_q);
    reply_go = !rsp_valid_q || rsp_o.ready;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == PageW'(TotalPages - 1)) state_d = S_IDLE;
      S_IDLE:  if (req_i.valid) state_d = S_PREP;
      S_PREP: begin
        if (prep_scan) begin
          state_d = S_SCAN;
        end else if (prep_len) begin
          state_d = S_LEN;
        end else begin
          state_d = S_REPLY;
        end
      end
      S_SCAN: begin
        if (hit_w) begin
          state_d = S_CLAIM;
        end else if (last_w) begin
          state_d = S_REPLY;
        end
      end
      S_CLAIM: if (cnt_q == LenW'(1)) state_d = S_REPLY;
      S_LEN: begin
        if (len_rd == '0 || kind_q == KIND_QUERY) begin
          state_d = S_REPLY;
        end else begin
          state_d = S_FREE;
        end
      end
      S_FREE: begin
        if (cnt_q == LenW'(1) || ptr_q == PageW'(TotalPages - 1)) state_d = S_REPLY;
      end
      S_REPLY: if (reply_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- datapath and memory control ----------------
  always_comb begin
    clr_d   = clr_q;
    n_d     = n_q;
    mask_d  = mask_q;
    lo_d    = lo_q;
    hic_d   = hic_q;
    ra_d    = ra_q;
    iss_d   = iss_q;
    pi_d    = pi_q;
    pv_d    = 1'b0;
    run_d   = run_q;
    fail_d  = fail_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    bp_d    = bp_q;
    st_d    = st_q;
    addr_d  = addr_q;
    bytes_d = bytes_q;

    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_st_d    = rsp_st_q;
    rsp_addr_d  = rsp_addr_q;
    rsp_bytes_d = rsp_bytes_q;

    mem_req           = '0;
    mem_req.bm_raddr  = ra_q;
    mem_req.len_raddr = bp_w[PageW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        mem_req.bm_we     = 1'b1;
        mem_req.bm_waddr  = clr_q;
        mem_req.len_we    = 1'b1;
        mem_req.len_waddr = clr_q;
        clr_d             = clr_q + PageW'(1);
      end
      S_IDLE: ;
      S_PREP: begin
        st_d    = prep_st;
        addr_d  = '0;
        bytes_d = '0;
        n_d     = n_w;
        ra_d    = prep_ra;
        lo_d    = prep_lo;
        hic_d   = prep_hic;
        mask_d  = prep_mask;
        iss_d   = 1'b1;
        run_d   = '0;
        bp_d    = bp_w[PageW-1:0];
        fail_d  = (kind_q == KIND_RESERVE) ? ST_TAKEN : ST_NO_FIT;
      end
      S_SCAN: begin
        // issue one bitmap read per cycle, evaluate the one that returned
        pv_d = iss_q;
        pi_d = ra_q;
        if (ra_q != lo_q) begin
          ra_d = ra_q - PageW'(1);
        end else begin
          iss_d = 1'b0;
        end
        if (pv_q) run_d = run_n;
        if (hit_w) begin
          ptr_d             = pi_q;
          cnt_d             = n_q[LenW-1:0];
          addr_d            = {{(32 - PageW - PageBits){1'b0}}, pi_q, {PageBits{1'b0}}};
          mem_req.len_we    = 1'b1;
          mem_req.len_waddr = pi_q;
          mem_req.len_wdata = n_q[LenW-1:0];
        end else if (last_w) begin
          st_d = fail_q;
        end
      end
      S_CLAIM: begin
        mem_req.bm_we    = 1'b1;
        mem_req.bm_waddr = ptr_q;
        mem_req.bm_wdata = 1'b1;
        ptr_d            = ptr_q + PageW'(1);
        cnt_d            = cnt_q - LenW'(1);
      end
      S_LEN: begin
        ptr_d = bp_q;
        cnt_d = len_rd;
        if (len_rd == '0) begin
          st_d = ST_NO_BLOCK;
        end else if (kind_q == KIND_QUERY) begin
          bytes_d = {{(32 - LenW - PageBits){1'b0}}, len_rd, {PageBits{1'b0}}};
        end else begin
          mem_req.len_we    = 1'b1;
          mem_req.len_waddr = bp_q;
        end
      end
      S_FREE: begin
        mem_req.bm_we    = 1'b1;
        mem_req.bm_waddr = ptr_q;
        ptr_d            = ptr_q + PageW'(1);
        cnt_d            = cnt_q - LenW'(1);
      end
      S_REPLY: begin
        if (reply_go) begin
          rsp_valid_d = 1'b1;
          rsp_st_d    = st_q;
          rsp_addr_d  = addr_q;
          rsp_bytes_d = bytes_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------- configuration port ----------------
  always_comb begin
    usable_d = usable_q;
    if (psel && penable && pwrite && paddr[2] == REG_USABLE_PAGES) begin
      usable_d = pwdata[UsableW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_USABLE_PAGES) ? {{(32 - UsableW){1'b0}}, usable_q} : '0;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      usable_q    <= UsableW'(UsableReset);
      clr_q       <= '0;
      pv_q        <= 1'b0;
      iss_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      usable_q    <= usable_d;
      clr_q       <= clr_d;
      pv_q        <= pv_d;
      iss_q       <= iss_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q  <= req_i.kind;
      size_q  <= req_i.size_bytes;
      min_q   <= req_i.min_address;
      max_q   <= req_i.max_address;
      align_q <= req_i.align_bytes;
      base_q  <= req_i.base_address;
    end
    n_q         <= n_d;
    mask_q      <= mask_d;
    lo_q        <= lo_d;
    hic_q       <= hic_d;
    ra_q        <= ra_d;
    pi_q        <= pi_d;
    run_q       <= run_d;
    fail_q      <= fail_d;
    ptr_q       <= ptr_d;
    cnt_q       <= cnt_d;
    bp_q        <= bp_d;
    st_q        <= st_d;
    addr_q      <= addr_d;
    bytes_q     <= bytes_d;
    rsp_st_q    <= rsp_st_d;
    rsp_addr_q  <= rsp_addr_d;
    rsp_bytes_q <= rsp_bytes_d;
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_st_q;
  assign rsp_o.block_address = rsp_addr_q;
  assign rsp_o.block_bytes   = rsp_bytes_q;

endmodule

`default_nettype wire

// ----- rtl/cpa_mem.sv -----
// Page bitmap and block length memories, with registered reads.
`timescale 1ns / 1ps
`default_nettype none

module cpa_mem (
  input  logic                    clk_i,
  input  cpa_pkg::mem_req_t       req_i,
  output logic                    bm_rdata_o,
  output logic [cpa_pkg::LenW-1:0] len_rdata_o
);
  import cpa_pkg::*;

  logic            bitmap_mem [TotalPages];
  logic [LenW-1:0] len_mem    [TotalPages];

  always_ff @(posedge clk_i) begin
    if (req_i.bm_we) begin
      bitmap_mem[req_i.bm_waddr] <= req_i.bm_wdata;
    end
    bm_rdata_o <= bitmap_mem[req_i.bm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.len_we) begin
      len_mem[req_i.len_waddr] <= req_i.len_wdata;
    end
    len_rdata_o <= len_mem[req_i.len_raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/cpa_checker.sv -----
// Port-level checks of the page allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cpa_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input cpa_pkg::status_e rsp_status_i,
  input logic [31:0]      rsp_addr_i,
  input logic [31:0]      rsp_bytes_i
);
  import cpa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before taken");

  a_addr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_addr_i != '0 |-> rsp_status_i == ST_OK)
    else $error("block address on a failed transaction");

  a_bytes_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_bytes_i != '0 |-> rsp_status_i == ST_OK && rsp_addr_i == '0)
    else $error("block size on a failed or allocating transaction");

  a_page_gran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_addr_i[PageBits-1:0] == '0 && rsp_bytes_i[PageBits-1:0] == '0)
    else $error("response not page granular");

endmodule

bind contiguous_page_allocator_unit cpa_checker u_cpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_status_i(rsp_o.status),
  .rsp_addr_i  (rsp_o.block_address),
  .rsp_bytes_i (rsp_o.block_bytes)
);

`default_nettype wire
